>>> design/tsmpe_pkg.sv
// Shared types and constants for the transport stream MPE/UDP extractor.
// No dependencies.
package tsmpe_pkg;

  localparam int unsigned MaxSectionBytes = 4095;
  localparam logic [7:0] PktBytes  = 8'd188;
  localparam logic [7:0] SyncByte  = 8'h47;
  localparam logic [7:0] TableId   = 8'h3e;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] StuffByte = 8'hff;

  typedef enum logic [2:0] {
    MD_HDR   = 3'd0,
    MD_SKIP  = 3'd1,
    MD_PCONT = 3'd2,
    MD_LOOP  = 3'd3,
    MD_CONT  = 3'd4,
    MD_IDLE  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    K_PAYLOAD = 2'd0,
    K_COMMIT  = 2'd1,
    K_DROP    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    AP_MORE = 2'd0,
    AP_DONE = 2'd1,
    AP_FAIL = 2'd2
  } ap_e;

  typedef enum logic [1:0] {
    REG_PID  = 2'd0,
    REG_IP   = 2'd1,
    REG_PORT = 2'd2
  } reg_e;

  typedef struct packed {
    logic [12:0] pid;
    logic [31:0] ip;
    logic [15:0] port;
  } cfg_t;

  typedef struct packed {
    logic [1:0] n;
    kind_e      k0;
    logic [7:0] b0;
    kind_e      k1;
    logic [7:0] b1;
  } res_t;

endpackage

>>> design/tsmpe_parser.sv
// Packet and section parser: holds the parse state, updates it per beat and
// produces up to two results. Depends on tsmpe_pkg.
module tsmpe_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              first_i,
  input  tsmpe_pkg::cfg_t   cfg_i,
  output tsmpe_pkg::res_t   res_o
);
  import tsmpe_pkg::*;

  typedef struct packed {
    logic [7:0]  pos;
    logic        pusi;
    logic        af;
    logic        fresh;
    mode_e       mode;
    logic [7:0]  alen;
    logic [7:0]  prem;
    logic [3:0]  lcc;
    logic [11:0] off;
    logic [11:0] slen;
    logic        hfail;
    logic [15:0] udp;
    logic        emit;
  } st_t;

  typedef struct packed {
    st_t  s;
    res_t r;
    ap_e  ap;
  } work_t;

  st_t st_q;
  work_t w;

  function automatic work_t put(work_t wi, kind_e k, logic [7:0] b);
    work_t wo;
    wo = wi;
    if (wi.r.n == 2'd0) begin
      wo.r.k0 = k; wo.r.b0 = b; wo.r.n = 2'd1;
    end else if (wi.r.n == 2'd1) begin
      wo.r.k1 = k; wo.r.b1 = b; wo.r.n = 2'd2;
    end
    return wo;
  endfunction

  function automatic work_t end_sec(work_t wi, kind_e k);
    work_t wo;
    wo = wi;
    if (wi.s.emit) wo = put(wo, k, 8'd0);
    wo.s.off = '0;
    wo.s.slen = '0;
    wo.s.hfail = 1'b0;
    wo.s.udp = '0;
    wo.s.emit = 1'b0;
    return wo;
  endfunction

  function automatic work_t append(work_t wi, logic [7:0] b, cfg_t c);
    work_t       wo;
    logic [11:0] o;
    logic [12:0] size;
    logic [15:0] cnt;
    logic [15:0] rel;
    wo = wi;
    o = wi.s.off;
    wo.ap = AP_MORE;
    size = 13'd3 + {1'b0, (wi.s.slen | {4'd0, b})};
    rel = {4'd0, o} - 16'd40;
    cnt = (wi.s.udp >= 16'd8) ? wi.s.udp - 16'd8 : 16'd0;
    if (o == 12'd0) begin
      wo.s.hfail = (b != TableId);
    end else if (o == 12'd1) begin
      wo.s.slen = {b[3:0], 8'd0};
    end else if (o == 12'd2) begin
      if (size <= 13'd3 || size > 13'(MaxSectionBytes)) begin
        wo.ap = AP_FAIL;
        return wo;
      end
      wo.s.slen = size[11:0];
    end else if (o == 12'd12) begin
      if (b[7:4] != 4'd4) wo.s.hfail = 1'b1;
    end else if (o == 12'd21) begin
      if (b != ProtoUdp) wo.s.hfail = 1'b1;
    end else if (o == 12'd28) begin
      if (b != c.ip[31:24]) wo.s.hfail = 1'b1;
    end else if (o == 12'd29) begin
      if (b != c.ip[23:16]) wo.s.hfail = 1'b1;
    end else if (o == 12'd30) begin
      if (b != c.ip[15:8]) wo.s.hfail = 1'b1;
    end else if (o == 12'd31) begin
      if (b != c.ip[7:0]) wo.s.hfail = 1'b1;
    end else if (o == 12'd34) begin
      if (b != c.port[15:8]) wo.s.hfail = 1'b1;
    end else if (o == 12'd35) begin
      if (b != c.port[7:0]) wo.s.hfail = 1'b1;
    end else if (o == 12'd36) begin
      wo.s.udp = {b, 8'd0};
    end else if (o == 12'd37) begin
      wo.s.udp = {wi.s.udp[15:8], b};
    end else if (o >= 12'd40 && wi.s.emit) begin
      if (rel < cnt) wo = put(wo, K_PAYLOAD, b);
    end
    o = o + 12'd1;
    wo.s.off = o;
    if (o == 12'd40 && !wo.s.hfail) wo.s.emit = 1'b1;
    if (o >= 12'd3 && o == wo.s.slen) wo.ap = AP_DONE;
    return wo;
  endfunction

  always_comb begin
    logic [7:0] p;
    logic [3:0] cc;
    logic       cc_ok;
    logic       pend;
    logic [7:0] avail;
    w = '0;
    w.s = st_q;
    w.r.k0 = K_PAYLOAD;
    w.r.k1 = K_PAYLOAD;
    w.ap = AP_MORE;
    p = st_q.pos;
    cc = st_q.prem[3:0];
    cc_ok = ((st_q.lcc + 4'd1) == cc);
    pend = (st_q.off != '0);
    avail = PktBytes - 8'd1 - p;
    if (first_i) begin
      w.s.pos = 8'd1;
      w.s.pusi = 1'b0;
      w.s.af = 1'b0;
      w.s.fresh = 1'b0;
      w.s.mode = (byte_i == SyncByte) ? MD_HDR : MD_IDLE;
    end else if (p != 8'd0 && p < PktBytes) begin
      w.s.pos = p + 8'd1;
      unique case (st_q.mode)
        MD_HDR: begin
          if (p == 8'd1) begin
            if (byte_i[6]) w.s.pusi = 1'b1;
            if (byte_i[4:0] != cfg_i.pid[12:8]) w.s.mode = MD_IDLE;
          end else if (p == 8'd2) begin
            if (byte_i != cfg_i.pid[7:0]) w.s.mode = MD_IDLE;
          end else if (p == 8'd3) begin
            if (!byte_i[4]) begin
              w.s.mode = MD_IDLE;
            end else begin
              w.s.prem = {4'd0, byte_i[3:0]};
              if (byte_i[5]) begin
                w.s.af = 1'b1; w.s.alen = 8'd0;
              end else begin
                w.s.alen = 8'd4;
              end
            end
          end else if (p == 8'd4 && st_q.af) begin
            if (byte_i >= 8'd183) w.s.mode = MD_IDLE;
            else w.s.alen = 8'd5 + byte_i;
          end else if (p == st_q.alen) begin
            w.s.lcc = cc;
            if (st_q.pusi) begin
              if (byte_i == 8'd0) begin
                w.s.mode = MD_LOOP;
              end else if (byte_i > avail) begin
                w = end_sec(w, K_DROP); w.s.mode = MD_IDLE;
              end else if (pend) begin
                if (!cc_ok) begin
                  w = end_sec(w, K_DROP); w.s.mode = MD_IDLE;
                end else begin
                  w.s.prem = byte_i; w.s.mode = MD_PCONT;
                end
              end else begin
                w.s.prem = byte_i; w.s.mode = MD_SKIP;
              end
            end else if (!pend) begin
              w.s.mode = MD_IDLE;
            end else if (!cc_ok) begin
              w = end_sec(w, K_DROP); w.s.mode = MD_IDLE;
            end else begin
              w.s.mode = MD_CONT;
              w = append(w, byte_i, cfg_i);
              if (w.ap == AP_DONE) begin
                w = end_sec(w, K_COMMIT); w.s.mode = MD_IDLE;
              end else if (w.ap == AP_FAIL) begin
                w = end_sec(w, K_DROP); w.s.mode = MD_IDLE;
              end
            end
          end
        end
        MD_SKIP: begin
          if (w.s.prem != 8'd0) w.s.prem = w.s.prem - 8'd1;
          if (w.s.prem == 8'd0) w.s.mode = MD_LOOP;
        end
        MD_PCONT: begin
          if (w.s.prem != 8'd0) w.s.prem = w.s.prem - 8'd1;
          w = append(w, byte_i, cfg_i);
          if (w.ap == AP_FAIL) begin
            w = end_sec(w, K_DROP); w.s.mode = MD_IDLE;
          end else if (w.ap == AP_DONE) begin
            if (w.s.prem == 8'd0) begin
              w = end_sec(w, K_COMMIT); w.s.mode = MD_LOOP;
            end else begin
              w = end_sec(w, K_DROP); w.s.mode = MD_IDLE;
            end
          end else if (w.s.prem == 8'd0) begin
            w = end_sec(w, K_DROP); w.s.mode = MD_IDLE;
          end
        end
        MD_LOOP: begin
          if (!st_q.fresh && byte_i == StuffByte) begin
            w.s.mode = MD_IDLE;
          end else begin
            if (!st_q.fresh) begin
              w = end_sec(w, K_DROP);
              w.s.fresh = 1'b1;
            end
            w = append(w, byte_i, cfg_i);
            if (w.ap == AP_DONE) begin
              w = end_sec(w, K_COMMIT); w.s.fresh = 1'b0;
            end else if (w.ap == AP_FAIL) begin
              w = end_sec(w, K_DROP); w.s.mode = MD_IDLE;
            end
          end
        end
        MD_CONT: begin
          w = append(w, byte_i, cfg_i);
          if (w.ap == AP_DONE) begin
            w = end_sec(w, K_COMMIT); w.s.mode = MD_IDLE;
          end else if (w.ap == AP_FAIL) begin
            w = end_sec(w, K_DROP); w.s.mode = MD_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  assign res_o = w.r;

  // all-zero state puts the parser in header mode with no packet open
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept_i) begin
      st_q <= w.s;
    end
  end

endmodule

>>> design/tsmpe_out_fifo.sv
// Four-entry result queue taking up to two results per cycle.
// Depends on tsmpe_pkg.
module tsmpe_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tsmpe_pkg::res_t   res_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full_o,
  output logic [1:0]        kind_o,
  output logic [7:0]        byte_o,
  output logic              last_o,
  output logic [2:0]        count_o
);
  import tsmpe_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } ent_t;

  ent_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic [1:0] npush;
  logic       do_pop;

  assign npush  = push_i ? res_i.n : 2'd0;
  assign do_pop = pop_i && (cnt_q != 3'd0);

  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) begin
      mem_q[wr_q] <= '{kind: res_i.k0, data: res_i.b0, last: (res_i.n == 2'd1)};
    end
    if (npush == 2'd2) begin
      mem_q[wr_q + 2'd1] <= '{kind: res_i.k1, data: res_i.b1, last: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + npush;
      rd_q  <= rd_q + {1'b0, do_pop};
      cnt_q <= cnt_q + {1'b0, npush} - {2'b0, do_pop};
    end
  end

  assign valid_o = (cnt_q != 3'd0);
  assign full_o  = (cnt_q > 3'd2);
  assign kind_o  = mem_q[rd_q].kind;
  assign byte_o  = mem_q[rd_q].data;
  assign last_o  = mem_q[rd_q].last;
  assign count_o = cnt_q;

endmodule

>>> design/ts_mpe_section_udp_extractor.sv
// Top level of the transport stream MPE section UDP extractor.
// Depends on tsmpe_pkg, tsmpe_parser and tsmpe_out_fifo.
//
// Input channel: one transport stream byte per beat (in_valid_i/in_stall_o),
// packet_first_i marking byte 0 of each 188-byte packet. Output channel
// (out_valid_o/out_stall_i): UDP payload bytes of matching sections, then a
// commit or drop status per datagram; run_last_o flags the last result of
// the input byte that caused it.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 PID, 1 dest IP,
// 2 dest port) and cfg_data_i; ready is always high. Write only while idle.
// Throughput: one byte per cycle while in_stall_o is low; the parser updates its
// state in the cycle the byte is accepted and writes its results into a four-entry
// queue, whose registers take them as the byte is accepted.
// A byte yielding two results takes two queue entries, popped one at a time;
// the input stalls while the queue holds more than two entries.
// Reset clears all parse state, the queue pointers and count, and the registers to zero.
// A stalled receiver holds the head result; the queue then fills and stalls
// the input side.
module ts_mpe_section_udp_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        packet_first_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        run_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import tsmpe_pkg::*;

  cfg_t       cfg_q;
  res_t       res;
  logic       accept;
  logic       full;
  logic [2:0] count;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PID:  cfg_q.pid  <= cfg_data_i[12:0];
        REG_IP:   cfg_q.ip   <= cfg_data_i;
        REG_PORT: cfg_q.port <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  tsmpe_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (stream_byte_i),
    .first_i  (packet_first_i),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  tsmpe_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .res_i   (res),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .full_o  (full),
    .kind_o  (item_kind_o),
    .byte_o  (payload_byte_o),
    .last_o  (run_last_o),
    .count_o (count)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= 3'd4) else $error("queue over capacity");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count > 3'd2) |-> in_stall_o) else $error("input open with queue full");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o == (count != 3'd0)) else $error("valid disagrees with queue");

endmodule
